/* hdl/assert_macros.svh */
// Assertion helpers included by the state machine module.
// The including module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mss_pkg.sv */
package mss_pkg;

    localparam int unsigned FLAG_W     = 4;
    localparam int unsigned NUM_DRIVES = 4;
    // Only drives that have a flag bit take part in the safety check.
    localparam int unsigned SAFETY_N   = (NUM_DRIVES < FLAG_W) ? NUM_DRIVES : FLAG_W;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_INIT      = 4'd1,
        ST_DISABLED  = 4'd2,
        ST_STANDBY   = 4'd3,
        ST_MOVING    = 4'd4,
        ST_HANDWHEEL = 4'd5,
        ST_LIMIT     = 4'd6,
        ST_FAULT     = 4'd7,
        ST_EMERGENCY = 4'd8,
        ST_TEST      = 4'd9
    } t_state;

    typedef enum logic [1:0] {
        DRV_NONE    = 2'd0,
        DRV_ENABLE  = 2'd1,
        DRV_DISABLE = 2'd2
    } t_drive_req;

    typedef enum logic [3:0] {
        ACT_NONE     = 4'd0,
        ACT_LOAD     = 4'd1,
        ACT_HOLD     = 4'd2,
        ACT_HW_ORG   = 4'd3,
        ACT_MOVE_ORG = 4'd4,
        ACT_MOVE     = 4'd5,
        ACT_HW       = 4'd6,
        ACT_TEST     = 4'd7,
        ACT_CAPTURE  = 4'd8
    } t_activity;

    // One control-cycle snapshot as held in the input register.
    typedef struct packed {
        logic              servo_on;
        logic              move;
        logic              reset_btn;
        logic              test_btn;
        logic              axis_any;
        logic              cmd_ready;
        logic              params_ok;
        logic              enable_ok;
        logic              disable_ok;
        logic [FLAG_W-1:0] lim;
        logic [FLAG_W-1:0] emg;
        logic [FLAG_W-1:0] flt;
    } t_snapshot;

    // Permitted target states, one bit per target, for each source state.
    function automatic logic [15:0] allowed_mask(t_state src);
        logic [15:0] m;
        m = '0;
        case (src)
            ST_IDLE:      m[ST_INIT] = 1'b1;
            ST_INIT:      m[ST_DISABLED] = 1'b1;
            ST_DISABLED: begin
                m[ST_STANDBY]   = 1'b1;
                m[ST_EMERGENCY] = 1'b1;
            end
            ST_STANDBY: begin
                m[ST_DISABLED]  = 1'b1;
                m[ST_HANDWHEEL] = 1'b1;
                m[ST_MOVING]    = 1'b1;
                m[ST_TEST]      = 1'b1;
                m[ST_LIMIT]     = 1'b1;
                m[ST_FAULT]     = 1'b1;
            end
            ST_MOVING, ST_HANDWHEEL: begin
                m[ST_STANDBY]  = 1'b1;
                m[ST_DISABLED] = 1'b1;
                m[ST_LIMIT]    = 1'b1;
                m[ST_FAULT]    = 1'b1;
            end
            ST_LIMIT: begin
                m[ST_STANDBY] = 1'b1;
                m[ST_FAULT]   = 1'b1;
            end
            ST_FAULT:     m[ST_STANDBY] = 1'b1;
            ST_EMERGENCY: m[ST_DISABLED] = 1'b1;
            ST_TEST: begin
                m[ST_STANDBY] = 1'b1;
                m[ST_LIMIT]   = 1'b1;
                m[ST_FAULT]   = 1'b1;
            end
            default:      m = '0;
        endcase
        return m;
    endfunction

    // Move to the target if the table permits it, else stay put.
    function automatic t_state request_state(t_state cur, t_state target);
        logic [15:0] m;
        m = allowed_mask(cur);
        return m[target] ? target : cur;
    endfunction

endpackage

/* hdl/motion_supervisor_state_machine.sv */
// Supervisory mode machine for a multi-drive motion controller.
// Input channel: one beat per control cycle carries the panel buttons, the
// drive acknowledgements and the per-drive limit, emergency and fault flags.
// A beat is taken when i_in_valid is high and o_in_stall is low.
// Output channel: one beat per input beat carries the resulting state, the
// drive enable or disable request, the activity code and the fault-reset flag.
// A beat is taken when o_out_valid is high and i_out_stall is low.
// A beat first lands in the input register; the safety check, transition
// table and state action are then evaluated on it in one pass and written
// to the result register together with the new state.
// One beat per cycle is taken while the receiver does not stall; the single
// pass of next-state logic between the two registers is what sets that figure.
// When the receiver stalls, the result register holds its beat, the waiting
// input beat stays in the input register and o_in_stall rises only once
// both registers are full.
// Reset returns the machine to idle with initialisation not done and the
// fault-reset flag clear, and empties both registers.
`include "assert_macros.svh"

module motion_supervisor_state_machine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_servo_on_button,
    input  logic       i_move_button,
    input  logic       i_reset_button,
    input  logic       i_test_button,
    input  logic       i_axis_select_any,
    input  logic       i_command_ready,
    input  logic       i_params_ok,
    input  logic       i_enable_ok,
    input  logic       i_disable_ok,
    input  logic [3:0] i_limit_flags,
    input  logic [3:0] i_emergency_flags,
    input  logic [3:0] i_fault_flags,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_current_state,
    output logic [1:0] o_drive_request,
    output logic [3:0] o_activity,
    output logic       o_fault_reset_request
);

    // Input register.
    logic                r_in_valid;
    mss_pkg::t_snapshot  r_in;

    // Machine state.
    mss_pkg::t_state     r_state;
    logic                r_init_done;
    logic                r_fault_reset;

    // Result register.
    logic                r_out_valid;
    mss_pkg::t_state     r_out_state;
    mss_pkg::t_drive_req r_out_drive;
    mss_pkg::t_activity  r_out_activity;
    logic                r_out_fault_reset;

    // Next values from the single evaluation pass.
    mss_pkg::t_state     n_state;
    logic                n_init_done;
    logic                n_fault_reset;
    mss_pkg::t_drive_req n_drive_req;
    mss_pkg::t_activity  n_activity;

    mss_pkg::t_state     w_safe_state;
    logic                w_in_accept;
    logic                w_advance;

    // The held beat moves on whenever the result register is empty or is
    // being emptied at this edge.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in.servo_on   <= i_servo_on_button;
            r_in.move       <= i_move_button;
            r_in.reset_btn  <= i_reset_button;
            r_in.test_btn   <= i_test_button;
            r_in.axis_any   <= i_axis_select_any;
            r_in.cmd_ready  <= i_command_ready;
            r_in.params_ok  <= i_params_ok;
            r_in.enable_ok  <= i_enable_ok;
            r_in.disable_ok <= i_disable_ok;
            r_in.lim        <= i_limit_flags;
            r_in.emg        <= i_emergency_flags;
            r_in.flt        <= i_fault_flags;
        end
    end

    // Safety check, then the action of the resulting state. The drive scan
    // applies each request at once, so a later drive sees the state that an
    // earlier drive left behind.
    always_comb begin
        w_safe_state  = r_state;
        n_init_done   = r_init_done;
        n_fault_reset = r_fault_reset;
        n_drive_req   = mss_pkg::DRV_NONE;
        n_activity    = mss_pkg::ACT_NONE;

        if (r_state > mss_pkg::ST_INIT) begin
            for (int d = 0; d < int'(mss_pkg::SAFETY_N); d++) begin
                if (r_in.lim[d]) begin
                    w_safe_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_LIMIT);
                end else if (r_in.emg[d]) begin
                    w_safe_state = mss_pkg::request_state(w_safe_state,
                                                          mss_pkg::ST_EMERGENCY);
                end else if (r_in.flt[d]) begin
                    w_safe_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_FAULT);
                end
            end
        end

        n_state = w_safe_state;

        case (w_safe_state)
            mss_pkg::ST_IDLE: begin
                n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_INIT);
            end
            mss_pkg::ST_INIT: begin
                if (!r_init_done) begin
                    n_activity = mss_pkg::ACT_LOAD;
                    if (r_in.params_ok) begin
                        n_init_done = 1'b1;
                    end
                end else begin
                    n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_DISABLED);
                end
            end
            mss_pkg::ST_DISABLED: begin
                if (r_in.servo_on) begin
                    n_drive_req = mss_pkg::DRV_ENABLE;
                    n_activity  = mss_pkg::ACT_HOLD;
                    if (r_in.enable_ok) begin
                        // The drives come up here, so the initial position
                        // is captured rather than merely held.
                        n_activity = mss_pkg::ACT_CAPTURE;
                        n_state    = mss_pkg::request_state(w_safe_state,
                                                            mss_pkg::ST_STANDBY);
                    end
                end
            end
            mss_pkg::ST_STANDBY: begin
                if (r_in.axis_any) begin
                    n_activity = mss_pkg::ACT_HW_ORG;
                    n_state    = mss_pkg::request_state(w_safe_state, mss_pkg::ST_HANDWHEEL);
                end else if (r_in.move) begin
                    n_activity = mss_pkg::ACT_MOVE_ORG;
                    n_state    = mss_pkg::request_state(w_safe_state, mss_pkg::ST_MOVING);
                end else if (r_in.test_btn) begin
                    n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_TEST);
                end else if (!r_in.servo_on) begin
                    n_drive_req = mss_pkg::DRV_DISABLE;
                    if (r_in.disable_ok) begin
                        n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_DISABLED);
                    end
                end else begin
                    n_activity = mss_pkg::ACT_HOLD;
                end
            end
            mss_pkg::ST_MOVING: begin
                if (r_in.move) begin
                    if (r_in.cmd_ready) begin
                        n_activity = mss_pkg::ACT_MOVE;
                    end
                end else begin
                    n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_STANDBY);
                end
            end
            mss_pkg::ST_HANDWHEEL: begin
                if (r_in.axis_any) begin
                    n_activity = mss_pkg::ACT_HW;
                end else begin
                    n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_STANDBY);
                end
            end
            mss_pkg::ST_LIMIT: begin
                if (!r_in.reset_btn) begin
                    n_drive_req = mss_pkg::DRV_DISABLE;
                end else begin
                    n_drive_req = mss_pkg::DRV_ENABLE;
                    n_activity  = mss_pkg::ACT_HOLD;
                    if (r_in.enable_ok) begin
                        n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_STANDBY);
                    end
                end
            end
            mss_pkg::ST_FAULT: begin
                // Apart from reset, the fault-reset flag is only ever updated here.
                if (!r_in.reset_btn) begin
                    n_fault_reset = 1'b0;
                end else begin
                    n_fault_reset = 1'b1;
                    n_drive_req   = mss_pkg::DRV_ENABLE;
                    n_activity    = mss_pkg::ACT_HOLD;
                    if (r_in.enable_ok) begin
                        n_state       = mss_pkg::request_state(w_safe_state,
                                                               mss_pkg::ST_STANDBY);
                        n_fault_reset = 1'b0;
                    end
                end
            end
            mss_pkg::ST_EMERGENCY: begin
                if (r_in.reset_btn) begin
                    n_drive_req = mss_pkg::DRV_DISABLE;
                    if (r_in.disable_ok) begin
                        n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_DISABLED);
                    end
                end
            end
            mss_pkg::ST_TEST: begin
                if (r_in.test_btn) begin
                    n_activity = mss_pkg::ACT_TEST;
                end else begin
                    n_state = mss_pkg::request_state(w_safe_state, mss_pkg::ST_STANDBY);
                end
            end
            default: begin
                n_state = w_safe_state;
            end
        endcase
    end

    // Machine state moves on together with the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mss_pkg::ST_IDLE;
            r_init_done   <= 1'b0;
            r_fault_reset <= 1'b0;
        end else if (w_advance) begin
            r_state       <= n_state;
            r_init_done   <= n_init_done;
            r_fault_reset <= n_fault_reset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_state       <= n_state;
            r_out_drive       <= n_drive_req;
            r_out_activity    <= n_activity;
            r_out_fault_reset <= n_fault_reset;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_current_state       = r_out_state;
    assign o_drive_request       = r_out_drive;
    assign o_activity            = r_out_activity;
    assign o_fault_reset_request = r_out_fault_reset;

    `MSS_ASSERT_NEXT(a_init_done_sticky, r_init_done, r_init_done, "init_done cleared")
    `MSS_ASSERT_NEXT(a_never_back_to_idle, r_state != mss_pkg::ST_IDLE,
                     r_state != mss_pkg::ST_IDLE, "machine returned to idle")
    `MSS_ASSERT_NOW(a_fault_reset_in_fault, $rose(r_fault_reset),
                    r_state == mss_pkg::ST_FAULT, "fault-reset raised outside fault")
    `MSS_ASSERT_NOW(a_moving_no_drive_req,
                    r_out_valid && (r_out_state == mss_pkg::ST_MOVING ||
                                    r_out_state == mss_pkg::ST_HANDWHEEL),
                    r_out_drive == mss_pkg::DRV_NONE, "drive request while moving")
    `MSS_ASSERT_NEXT(a_advance_fills_output, w_advance, r_out_valid,
                     "result beat lost after advance")

endmodule
